[rtl/core/cpac_pkg.sv]
// shared types and constants for the convex polygon area/centroid core
// no dependencies; imported by the controller, datapath and top level
package cpac_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int COUNT_W      = $clog2(MAX_VERTICES + 1);
   localparam int COORD_W      = 16;
   localparam int AREA_W       = 40;
   localparam int WSUM_W       = 58;
   localparam int STEP_W       = 6;

   // sequencer step limits
   localparam int CROSS_LAST  = 5;
   localparam int SQUARE_LAST = 2;
   localparam int SQRT_LAST   = 35;
   localparam int WEIGHT_LAST = 5;
   localparam int DIV_LAST    = 17;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_CROSS,
      ST_SQUARE,
      ST_SQRT,
      ST_AREA,
      ST_WEIGHT,
      ST_UPDATE,
      ST_DIV,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic              load_in;
      logic              set_first;
      logic              update_prev;
      logic              inc_count;
      logic              set_ovf;
      logic              cross_en;
      logic              sq_en;
      logic              sqrt_en;
      logic              area_en;
      logic              wt_en;
      logic              div_en;
      logic              out_load;
      logic [STEP_W-1:0] step;
      logic [1:0]        axis;
   } cmd_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               last;
      logic               area_zero;
      logic               out_free;
   } status_type;

endpackage

[rtl/core/cpac_ctrl.sv]
// sequencer for the polygon core: steps each vertex through cross product,
// square sum, square root, area and weighted sums, then the centroid divides
module cpac_ctrl
   import cpac_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [1:0]        axis_ff, axis_in;
   state_type         finish_state;

   assign req_tready   = (state_ff == ST_IDLE);
   assign finish_state = status.area_zero ? ST_OUTPUT : ST_DIV;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         axis_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         axis_ff  <= axis_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff + STEP_W'(1);
      axis_in  = axis_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            axis_in = '0;
            if (req_tvalid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            step_in = '0;
            axis_in = '0;
            if (status.count >= COUNT_W'(MAX_VERTICES) || status.count < COUNT_W'(2)) begin
               state_in = status.last ? finish_state : ST_IDLE;
            end else begin
               state_in = ST_CROSS;
            end
         end
         ST_CROSS: begin
            if (step_ff == STEP_W'(CROSS_LAST)) begin
               state_in = ST_SQUARE;
               step_in  = '0;
            end
         end
         ST_SQUARE: begin
            if (step_ff == STEP_W'(SQUARE_LAST)) begin
               state_in = ST_SQRT;
               step_in  = '0;
            end
         end
         ST_SQRT: begin
            if (step_ff == STEP_W'(SQRT_LAST)) begin
               state_in = ST_AREA;
               step_in  = '0;
            end
         end
         ST_AREA: begin
            state_in = ST_WEIGHT;
            step_in  = '0;
         end
         ST_WEIGHT: begin
            if (step_ff == STEP_W'(WEIGHT_LAST)) begin
               state_in = ST_UPDATE;
               step_in  = '0;
            end
         end
         ST_UPDATE: begin
            step_in  = '0;
            state_in = status.last ? finish_state : ST_IDLE;
         end
         ST_DIV: begin
            if (step_ff == STEP_W'(DIV_LAST)) begin
               step_in = '0;
               if (axis_ff == 2'd2) state_in = ST_OUTPUT;
               else axis_in = axis_ff + 2'd1;
            end
         end
         ST_OUTPUT: begin
            step_in = '0;
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd      = '0;
      cmd.step = step_ff;
      cmd.axis = axis_ff;
      case (state_ff)
         ST_IDLE: cmd.load_in = req_tvalid;
         ST_DISPATCH: begin
            if (status.count >= COUNT_W'(MAX_VERTICES)) begin
               cmd.set_ovf = 1'b1;
            end else if (status.count < COUNT_W'(2)) begin
               cmd.set_first   = (status.count == '0);
               cmd.update_prev = 1'b1;
               cmd.inc_count   = 1'b1;
            end
         end
         ST_CROSS:  cmd.cross_en = 1'b1;
         ST_SQUARE: cmd.sq_en    = 1'b1;
         ST_SQRT:   cmd.sqrt_en  = 1'b1;
         ST_AREA:   cmd.area_en  = 1'b1;
         ST_WEIGHT: cmd.wt_en    = 1'b1;
         ST_UPDATE: begin
            cmd.update_prev = 1'b1;
            cmd.inc_count   = 1'b1;
         end
         ST_DIV:    cmd.div_en   = 1'b1;
         ST_OUTPUT: cmd.out_load = status.out_free;
         default: ;
      endcase
   end

endmodule

[rtl/core/cpac_datapath.sv]
// datapath: vertex registers, cross product, bit-pair square root,
// area and weighted accumulators, restoring divider and result register
module cpac_datapath
   import cpac_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   output status_type   status,
   input  logic [47:0]  req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [87:0]  rsp_tdata,
   output logic [1:0]   rsp_tuser
);

   logic signed [COORD_W-1:0] cur_ff [3];
   logic signed [COORD_W-1:0] first_ff [3];
   logic signed [COORD_W-1:0] prev_ff [3];
   logic                      last_ff;
   logic [COUNT_W-1:0]        count_ff;
   logic                      ovf_ff;
   logic signed [34:0]        cr_ff [3];
   logic [71:0]               sum_ff;
   logic [37:0]               rem_ff;
   logic [35:0]               root_ff;
   logic [AREA_W-1:0]         area_ff;
   logic signed [WSUM_W-1:0]  w_ff [3];
   logic signed [59:0]        acc_ff;
   logic [59:0]               drem_ff, dsh_ff;
   logic [15:0]               q_ff;
   logic                      neg_ff, sat_ff;
   logic signed [COORD_W-1:0] c_ff [3];
   logic                      out_valid_ff;
   logic [87:0]               out_data_ff;
   logic [1:0]                out_user_ff;

   // cross product operand selection
   logic [1:0]         ia, ib;
   logic signed [16:0] ea, eb;
   logic signed [33:0] cprod;
   logic [1:0]         ck;
   always_comb begin
      case (cmd.step[2:0])
         3'd0: begin ia = 2'd1; ib = 2'd2; end
         3'd1: begin ia = 2'd2; ib = 2'd1; end
         3'd2: begin ia = 2'd2; ib = 2'd0; end
         3'd3: begin ia = 2'd0; ib = 2'd2; end
         3'd4: begin ia = 2'd0; ib = 2'd1; end
         default: begin ia = 2'd1; ib = 2'd0; end
      endcase
   end
   assign ck    = cmd.step[2:1];
   assign ea    = 17'(prev_ff[ia]) - 17'(first_ff[ia]);
   assign eb    = 17'(cur_ff[ib]) - 17'(first_ff[ib]);
   assign cprod = 34'(ea) * 34'(eb);

   // square of one cross component
   logic signed [34:0] crs;
   logic [33:0]        cmag;
   logic [67:0]        csq;
   assign crs  = cr_ff[cmd.step[1:0]];
   assign cmag = crs[34] ? 34'(-crs) : 34'(crs);
   assign csq  = 68'(cmag) * 68'(cmag);

   // square root, two radicand bits per step
   logic [39:0] r2, trial;
   assign r2    = {rem_ff, sum_ff[71:70]};
   assign trial = {2'b00, root_ff, 2'b01};

   // triangle area and weighted update
   logic [AREA_W-1:0]  tri_area;
   logic [40:0]        area_sum;
   logic [1:0]         wa;
   logic signed [17:0] csum;
   logic signed [20:0] tlo, thi;
   logic signed [38:0] plo, phi;
   logic signed [59:0] wtot;
   localparam logic signed [59:0] WMAX = (60'sd1 <<< (WSUM_W - 1)) - 60'sd1;
   localparam logic signed [59:0] WMIN = -(60'sd1 <<< (WSUM_W - 1));
   assign tri_area = AREA_W'(root_ff[35:1]);
   assign area_sum = {1'b0, area_ff} + {1'b0, tri_area};
   assign wa       = cmd.step[2:1];
   assign csum     = 18'(first_ff[wa]) + 18'(prev_ff[wa]) + 18'(cur_ff[wa]);
   assign tlo      = {1'b0, tri_area[19:0]};
   assign thi      = {1'b0, tri_area[39:20]};
   assign plo      = 39'(tlo) * 39'(csum);
   assign phi      = 39'(thi) * 39'(csum);
   assign wtot     = acc_ff + (60'(phi) <<< 20);

   // divider
   logic [41:0]        den;
   logic signed [59:0] wsel;
   logic [59:0]        wmag;
   logic [15:0]        qmag;
   logic signed [15:0] cval;
   assign den  = {area_ff, 1'b0} + {2'b00, area_ff};
   assign wsel = 60'(w_ff[cmd.axis]);
   assign wmag = wsel[59] ? 60'(-wsel) : 60'(wsel);
   assign qmag = q_ff;
   always_comb begin
      if (!neg_ff) begin
         cval = (sat_ff || qmag[15]) ? 16'sh7fff : $signed(qmag);
      end else if (sat_ff || qmag > 16'h8000) begin
         cval = 16'sh8000;
      end else begin
         cval = $signed(-qmag);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         cur_ff[0] <= req_tdata[15:0];
         cur_ff[1] <= req_tdata[31:16];
         cur_ff[2] <= req_tdata[47:32];
         last_ff   <= req_tlast;
      end
      if (cmd.cross_en) begin
         if (!cmd.step[0]) cr_ff[ck] <= 35'(cprod);
         else cr_ff[ck] <= cr_ff[ck] - 35'(cprod);
      end
      if (cmd.sq_en) begin
         sum_ff  <= (cmd.step == '0) ? 72'(csq) : sum_ff + 72'(csq);
         rem_ff  <= '0;
         root_ff <= '0;
      end
      if (cmd.sqrt_en) begin
         sum_ff <= {sum_ff[69:0], 2'b00};
         if (r2 >= trial) begin
            rem_ff  <= 38'(r2 - trial);
            root_ff <= {root_ff[34:0], 1'b1};
         end else begin
            rem_ff  <= 38'(r2);
            root_ff <= {root_ff[34:0], 1'b0};
         end
      end
      if (cmd.wt_en) begin
         if (!cmd.step[0]) begin
            acc_ff <= 60'(w_ff[wa]) + 60'(plo);
         end else if (wtot > WMAX) begin
            w_ff[wa] <= WSUM_W'(WMAX);
         end else if (wtot < WMIN) begin
            w_ff[wa] <= WSUM_W'(WMIN);
         end else begin
            w_ff[wa] <= WSUM_W'(wtot);
         end
      end
      if (cmd.div_en) begin
         if (cmd.step == '0) begin
            drem_ff <= wmag;
            neg_ff  <= wsel[59];
            sat_ff  <= wmag >= (60'(den) << 16);
            dsh_ff  <= 60'(den) << 15;
            q_ff    <= '0;
         end else if (cmd.step == STEP_W'(DIV_LAST)) begin
            c_ff[cmd.axis] <= cval;
         end else begin
            dsh_ff <= dsh_ff >> 1;
            if (drem_ff >= dsh_ff) begin
               drem_ff <= drem_ff - dsh_ff;
               q_ff    <= {q_ff[14:0], 1'b1};
            end else begin
               q_ff    <= {q_ff[14:0], 1'b0};
            end
         end
      end
      if (cmd.out_load) begin
         if (area_ff == '0) out_data_ff <= {48'd0, area_ff};
         else out_data_ff <= {c_ff[2], c_ff[1], c_ff[0], area_ff};
         out_user_ff <= {ovf_ff, area_ff == '0};
      end
   end

   // polygon state, cleared by reset and after each result
   always_ff @(posedge clock) begin
      if (reset || cmd.out_load) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         area_ff  <= '0;
         for (int k = 0; k < 3; k++) begin
            first_ff[k] <= '0;
            prev_ff[k]  <= '0;
            w_ff[k]     <= '0;
         end
      end else begin
         if (cmd.set_ovf) ovf_ff <= 1'b1;
         if (cmd.inc_count) count_ff <= count_ff + COUNT_W'(1);
         if (cmd.set_first) first_ff <= cur_ff;
         if (cmd.update_prev) prev_ff <= cur_ff;
         if (cmd.area_en) area_ff <= area_sum[40] ? '1 : area_sum[AREA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (cmd.out_load) out_valid_ff <= 1'b1;
      else if (rsp_tready) out_valid_ff <= 1'b0;
   end

   assign rsp_tvalid       = out_valid_ff;
   assign rsp_tdata        = out_data_ff;
   assign rsp_tuser        = out_user_ff;
   assign status.count     = count_ff;
   assign status.last      = last_ff;
   assign status.area_zero = (area_ff == '0);
   assign status.out_free  = !out_valid_ff || rsp_tready;

endmodule

[rtl/core/convex_polygon_area_centroid_core.sv]
// convex polygon fan area and centroid core
// a vertex that closes a triangle passes through accept, dispatch, 6 cross, 3 square,
// 36 root steps of the bit-pair square root, area, 6 weighted steps and update;
// the first two vertices and overflowed ones pass only through accept and dispatch
// the last vertex adds restoring division (18 steps per axis) when area is nonzero,
// plus an output step and any wait for the result register to drain
// reset is synchronous active high and clears the sequencer, polygon state and output valid
module convex_polygon_area_centroid_core
   import cpac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // vx, vy, vz
   input  logic        req_tlast,   // last_vertex
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // area, cx, cy, cz
   output logic [1:0]  rsp_tuser    // degenerate, overflow
);

   cmd_type    cmd;
   status_type status;

   cpac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cpac_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[rtl/core/cpac_checker.sv]
// port-level checks for the polygon core, bound to the top level
// depends on convex_polygon_area_centroid_core ports only
module cpac_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // one item at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("accepted an item back to back");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // degenerate means zero area and zero centroid
   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 88'd0)
      else $error("degenerate result not zero");

   a_nonzero_area: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[39:0] != 40'd0)
      else $error("zero area without degenerate flag");

endmodule

bind convex_polygon_area_centroid_core cpac_checker u_cpac_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[dv/tb_convex_polygon_area_centroid_core.sv]
// testbench for the convex polygon fan area and centroid core
// streams random and directed polygons, checks each result item against a predictor
// depends on cpac_pkg and convex_polygon_area_centroid_core
module tb_convex_polygon_area_centroid_core;
   timeunit 1ns;
   timeprecision 1ps;
   import cpac_pkg::*;

   typedef struct packed {
      logic signed [15:0] vz;
      logic signed [15:0] vy;
      logic signed [15:0] vx;
      logic               last;
   } vertex_item_type;

   typedef struct packed {
      logic [1:0]  flags;
      logic [87:0] data;
   } poly_result_type;

   localparam longint AREA_TOP = (64'd1 << 40) - 1;
   localparam longint WSUM_TOP = (64'sd1 <<< 57) - 1;
   localparam longint WSUM_BOT = -WSUM_TOP - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   convex_polygon_area_centroid_core u_top (.*);

   always #5 clock = ~clock;

   vertex_item_type pending_vertices[$];
   poly_result_type expected_results[$];
   int  mismatches = 0;
   longint cycles = 0;
   bit  gaps_on = 1'b1;
   bit  hold_send = 1'b0;
   bit  req_taken = 1'b0;
   int  send_gap = 0;
   int  recv_gap = 0;

   // polygon state of the predictor
   logic signed [15:0] v0[3], vp[3];
   int unsigned vcount;
   longint unsigned area_acc;
   longint wsum[3];
   bit ovf_seen;

   function automatic void clear_polygon();
      for (int k = 0; k < 3; k++) begin
         v0[k] = 0;
         vp[k] = 0;
         wsum[k] = 0;
      end
      vcount = 0;
      area_acc = 0;
      ovf_seen = 0;
   endfunction

   function automatic longint unsigned root_trunc(logic [127:0] n);
      logic [127:0] t;
      longint unsigned r;
      r = 0;
      for (int b = 40; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= n) r = t;
      end
      return r;
   endfunction

   function automatic logic [15:0] centroid_axis(longint w, longint den);
      longint q;
      q = w / den;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   function automatic void fold_triangle(logic signed [15:0] c[3]);
      longint e1[3], e2[3], cr[3];
      logic [127:0] s;
      longint unsigned tri_area;
      logic signed [127:0] w;
      for (int k = 0; k < 3; k++) begin
         e1[k] = longint'(vp[k]) - longint'(v0[k]);
         e2[k] = longint'(c[k]) - longint'(v0[k]);
      end
      cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
      cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
      cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
      s = 0;
      for (int k = 0; k < 3; k++)
         s += 128'(cr[k] < 0 ? -cr[k] : cr[k]) * 128'(cr[k] < 0 ? -cr[k] : cr[k]);
      tri_area = root_trunc(s) >> 1;
      area_acc += tri_area;
      if (area_acc > AREA_TOP) area_acc = AREA_TOP;
      for (int k = 0; k < 3; k++) begin
         w = 128'(wsum[k]) + 128'(tri_area) *
             128'(longint'(v0[k]) + longint'(vp[k]) + longint'(c[k]));
         if (w > WSUM_TOP) w = WSUM_TOP;
         if (w < WSUM_BOT) w = WSUM_BOT;
         wsum[k] = longint'(w);
      end
   endfunction

   function automatic void predict_vertex(vertex_item_type it);
      logic signed [15:0] c[3];
      poly_result_type r;
      longint den;
      c[0] = it.vx;
      c[1] = it.vy;
      c[2] = it.vz;
      if (vcount >= MAX_VERTICES) begin
         ovf_seen = 1;
      end else begin
         if (vcount == 0) v0 = c;
         else if (vcount >= 2) fold_triangle(c);
         vp = c;
         vcount++;
      end
      if (!it.last) return;
      r.data = '0;
      r.data[39:0] = area_acc[39:0];
      if (area_acc == 0) begin
         r.flags[0] = 1'b1;
      end else begin
         den = longint'(area_acc) * 3;
         r.data[55:40] = centroid_axis(wsum[0], den);
         r.data[71:56] = centroid_axis(wsum[1], den);
         r.data[87:72] = centroid_axis(wsum[2], den);
         r.flags[0] = 1'b0;
      end
      r.flags[1] = ovf_seen;
      expected_results.push_back(r);
      clear_polygon();
   endfunction

   function automatic vertex_item_type mk(int x, int y, int z, bit l);
      vertex_item_type v;
      v.vx = 16'(x);
      v.vy = 16'(y);
      v.vz = 16'(z);
      v.last = l;
      return v;
   endfunction

   // convex polygon: points on an ellipse in a random plane, small or full scale
   task automatic push_polygon(int n, int scale);
      int cx, cy, cz, ax, ay, az, bx, by, bz;
      real ang, ca, sa;
      cx = $urandom_range(2 * scale) - scale;
      cy = $urandom_range(2 * scale) - scale;
      cz = $urandom_range(2 * scale) - scale;
      ax = $urandom_range(2 * scale) - scale;
      ay = $urandom_range(2 * scale) - scale;
      az = $urandom_range(2 * scale) - scale;
      bx = $urandom_range(2 * scale) - scale;
      by = $urandom_range(2 * scale) - scale;
      bz = $urandom_range(2 * scale) - scale;
      for (int i = 0; i < n; i++) begin
         ang = 6.283185307 * i / n;
         ca = $cos(ang);
         sa = $sin(ang);
         pending_vertices.push_back(mk($rtoi(cx + ax * ca + bx * sa),
            $rtoi(cy + ay * ca + by * sa), $rtoi(cz + az * ca + bz * sa), i == n - 1));
      end
   endtask

   // driver
   always @(negedge clock) begin
      cycles++;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (!hold_send && pending_vertices.size() > 0 &&
                      !(gaps_on && $urandom_range(9) == 0)) begin
            vertex_item_type v;
            v = pending_vertices.pop_front();
            req_tdata <= {v.vz, v.vy, v.vx};
            req_tlast <= v.last;
            req_tvalid <= 1'b1;
            if (gaps_on && $urandom_range(7) == 0) send_gap = $urandom_range(17, 1);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      if (recv_gap > 0) begin
         recv_gap--;
         rsp_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(5) == 0) begin
         recv_gap = $urandom_range(16, 0);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      req_taken = !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready)
         predict_vertex(mk($signed(req_tdata[15:0]), $signed(req_tdata[31:16]),
                           $signed(req_tdata[47:32]), req_tlast));
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %h %b", rsp_tdata, rsp_tuser);
         end else begin
            poly_result_type e;
            e = expected_results.pop_front();
            if (e.data[39:0] !== rsp_tdata[39:0] || e.data[55:40] !== rsp_tdata[55:40] ||
                e.data[71:56] !== rsp_tdata[71:56] || e.data[87:72] !== rsp_tdata[87:72] ||
                e.flags[0] !== rsp_tuser[0] || e.flags[1] !== rsp_tuser[1]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp area %h c %h %h %h flags %b, got %h %h %h %h %b",
                     e.data[39:0], e.data[55:40], e.data[71:56], e.data[87:72], e.flags,
                     rsp_tdata[39:0], rsp_tdata[55:40], rsp_tdata[71:56], rsp_tdata[87:72],
                     rsp_tuser);
            end
         end
      end
   end

   // watchdog: the time for 450 items plus division and stalls, taken many times over
   always @(posedge clock) begin
      if (cycles > 600000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int n;
      clear_polygon();
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: lone vertex, two vertices, collinear, extremes, one triangle, repeated point
      pending_vertices.push_back(mk(100, -200, 300, 1));
      pending_vertices.push_back(mk(-32768, 32767, 0, 0));
      pending_vertices.push_back(mk(32767, -32768, -1, 1));
      pending_vertices.push_back(mk(0, 0, 0, 0));
      pending_vertices.push_back(mk(256, 256, 256, 0));
      pending_vertices.push_back(mk(512, 512, 512, 1));
      pending_vertices.push_back(mk(-32768, -32768, -32768, 0));
      pending_vertices.push_back(mk(32767, -32768, 32767, 0));
      pending_vertices.push_back(mk(-32768, 32767, 32767, 0));
      pending_vertices.push_back(mk(32767, 32767, -32768, 1));
      pending_vertices.push_back(mk(0, 0, 0, 0));
      pending_vertices.push_back(mk(1024, 0, 0, 0));
      pending_vertices.push_back(mk(0, 1024, 0, 1));
      pending_vertices.push_back(mk(-1, -1, -1, 0));
      pending_vertices.push_back(mk(-1, -1, -1, 0));
      pending_vertices.push_back(mk(-1, -1, -1, 1));

      // wait for all results before the random part
      wait (pending_vertices.size() == 0 && !req_tvalid);
      hold_send = 1'b1;
      wait (expected_results.size() == 0);
      hold_send = 1'b0;

      // overflow: one polygon past the vertex limit
      push_polygon(MAX_VERTICES + 3, 20000);
      n = 0;
      while (n < 300) begin
         int k;
         case ($urandom_range(9))
            0: begin
               // noise polygon of random vertices
               k = $urandom_range(6, 1);
               for (int i = 0; i < k; i++)
                  pending_vertices.push_back(mk($urandom_range(65535) - 32768,
                     $urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                     i == k - 1));
            end
            1: begin
               k = $urandom_range(12, 3);
               push_polygon(k, 32000);
            end
            default: begin
               k = $urandom_range(8, 3);
               push_polygon(k, $urandom_range(4000, 4));
            end
         endcase
         n += k;
      end
      push_polygon(MAX_VERTICES + 1, 500);

      // final stretch with no idling
      wait (pending_vertices.size() < 40);
      gaps_on = 1'b0;
      wait (pending_vertices.size() == 0 && !req_tvalid);
      wait (expected_results.size() == 0);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

[convex_polygon_area_centroid_core.f]
rtl/core/cpac_pkg.sv
rtl/core/cpac_ctrl.sv
rtl/core/cpac_datapath.sv
rtl/core/convex_polygon_area_centroid_core.sv
rtl/core/cpac_checker.sv
dv/tb_convex_polygon_area_centroid_core.sv
